FILE: sv/fill_heat_fog_sequencer_assert.svh
// Assertion macros shared by the checker of the fill, heat and fog sequencer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FILL_HEAT_FOG_SEQUENCER_ASSERT_SVH
`define FILL_HEAT_FOG_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FHFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fill_heat_fog_sequencer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FHFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fill_heat_fog_sequencer: next-cycle check failed");

`endif

FILE: sv/fhfs_pkg.sv
// Types and constants of the fill, heat and fog sequencer.
// Used by the top level and by its checker; depends on nothing else.
package fhfs_pkg;

    localparam int TEMP_W      = 14;
    localparam int PHASE_W     = 3;
    localparam int TIME_IN_W   = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    // Input tdata bit positions.
    localparam int IN_TIME_LSB   = 0;
    localparam int IN_WATER_BIT  = 32;
    localparam int IN_TEMP_LSB   = 33;
    localparam int IN_OVER_BIT   = 47;
    localparam int IN_WFAULT_BIT = 48;

    // Output tdata bit positions.
    localparam int OUT_PUMP_BIT   = 3;
    localparam int OUT_HEATER_BIT = 4;
    localparam int OUT_DOSE_BIT   = 5;
    localparam int OUT_VENTS_BIT  = 6;

    // Drive level bits in the internal drive register.
    localparam int DRV_PUMP   = 0;
    localparam int DRV_HEATER = 1;
    localparam int DRV_DOSE   = 2;
    localparam int DRV_VENTS  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH    = 2'd3;

    // Configuration reset values: band edges 108.0 and 115.0 degrees.
    localparam logic [CFG_DATA_W-1:0]    FILL_TIMEOUT_RST = 32'd120000;
    localparam logic [CFG_DATA_W-1:0]    HEAT_TIMEOUT_RST = 32'd600000;
    localparam logic signed [TEMP_W-1:0] BAND_LOW_RST     = 14'sd1728;
    localparam logic signed [TEMP_W-1:0] BAND_HIGH_RST    = 14'sd1840;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 3'd0,
        PH_FILL  = 3'd1,
        PH_HEAT  = 3'd2,
        PH_FOG   = 3'd3,
        PH_FAULT = 3'd4
    } phase_t;

endpackage

FILE: sv/fill_heat_fog_sequencer.sv
// Top level of the fill, heat and fog sequencer: phase machine and output register.
// Depends on fhfs_pkg for field positions, register indexes and the phase type.
//
// Usage. Each transaction on the slave stream is one run tick carrying the
// millisecond time, the water level flag, the chamber temperature and two
// externally computed fault verdicts. For every tick the block returns exactly
// one transaction on the master stream with the phase after the step and the
// four drive levels (pump, heater, dosing valve, vents).
// The phase machine walks idle, fill, heat, fog and fault. Fill and heat are
// each guarded by a timeout measured on the wrapping time counter, modulo
// 2^TIME_BITS. Fault is latched until reset and forces every drive low on the
// tick after it is entered.
// The result of a tick is registered and offered in the cycle after the tick is
// taken. Throughput is one tick per cycle while the receiver does not stall; the
// phase registers are updated in the same cycle the tick is taken, so nothing
// limits the rate but the output register.
// When the receiver stalls, the result waits in the output register and a new
// tick is taken only in the cycle the waiting result is taken.
// Reset clears the phase to idle, disarms both timers, drops all drives and loads the
// configuration registers with their defaults. The user must write configuration
// through cfg_we, cfg_index and cfg_data while idle; the block does not enforce it.
module fill_heat_fog_sequencer #(
    parameter int TIME_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream, tdata from bit 0: time_ms[31:0], water_present,
    // chamber_temp[13:0], over_temp, water_fault, zero padding.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fhfs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Master stream, tdata from bit 0: phase[2:0], pump_on, heater_on,
    // dosing_valve_on, vents_on, zero padding.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [fhfs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [fhfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fhfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import fhfs_pkg::*;

    // Timeouts are compared at the wider of the time width and the register width.
    localparam int CMP_W = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0]    fill_timeout_reg;
    logic [CFG_DATA_W-1:0]    heat_timeout_reg;
    logic signed [TEMP_W-1:0] band_low_reg;
    logic signed [TEMP_W-1:0] band_high_reg;

    // Sequencer state.
    phase_t                   phase_reg, phase_next;
    logic [TIME_BITS-1:0]     fill_start_reg, fill_start_next;
    logic                     fill_armed_reg, fill_armed_next;
    logic [TIME_BITS-1:0]     heat_start_reg, heat_start_next;
    logic                     heat_armed_reg, heat_armed_next;
    logic [3:0]               drive_reg, drive_next;

    // Output register.
    logic                     m_valid_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Unpacked tick fields.
    logic [TIME_BITS-1:0]     now;
    logic                     water;
    logic signed [TEMP_W-1:0] temp;
    logic                     over;
    logic                     wfault;

    // Derived values for the step.
    logic                     accept;
    logic [TIME_BITS-1:0]     fill_elapsed;
    logic [TIME_BITS-1:0]     heat_elapsed;
    logic                     fill_expired;
    logic                     heat_expired;
    logic                     below_band;
    logic                     above_band;
    phase_t                   phase_out;

    assign now    = TIME_BITS'(s_axis_tdata[IN_TIME_LSB +: TIME_IN_W]);
    assign water  = s_axis_tdata[IN_WATER_BIT];
    assign temp   = signed'(s_axis_tdata[IN_TEMP_LSB +: TEMP_W]);
    assign over   = s_axis_tdata[IN_OVER_BIT];
    assign wfault = s_axis_tdata[IN_WFAULT_BIT];

    // A new tick is taken whenever the output register is empty or is being emptied.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // An unarmed timer counts from the present tick, so its elapsed time is zero.
    assign fill_elapsed = fill_armed_reg ? (now - fill_start_reg) : '0;
    assign heat_elapsed = heat_armed_reg ? (now - heat_start_reg) : '0;
    assign fill_expired = CMP_W'(fill_elapsed) > CMP_W'(fill_timeout_reg);
    assign heat_expired = CMP_W'(heat_elapsed) > CMP_W'(heat_timeout_reg);

    assign below_band = temp < band_low_reg;
    assign above_band = temp > band_high_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        fill_start_next = fill_start_reg;
        fill_armed_next = fill_armed_reg;
        heat_start_next = heat_start_reg;
        heat_armed_next = heat_armed_reg;
        drive_next      = drive_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                phase_next = PH_FILL;
            end
            PH_FILL:
            begin
                drive_next[DRV_PUMP] = 1'b1;
                if (!fill_armed_reg)
                begin
                    fill_start_next = now;
                end
                fill_armed_next = 1'b1;
                if (water)
                begin
                    drive_next[DRV_PUMP] = 1'b0;
                    fill_armed_next      = 1'b0;
                    phase_next           = PH_HEAT;
                end
                else if (fill_expired)
                begin
                    drive_next[DRV_PUMP] = 1'b0;
                    phase_next           = PH_FAULT;
                end
            end
            PH_HEAT:
            begin
                if (!heat_armed_reg)
                begin
                    heat_start_next = now;
                end
                heat_armed_next = 1'b1;
                if (over)
                begin
                    drive_next[DRV_HEATER] = 1'b0;
                    phase_next             = PH_FAULT;
                end
                else if (!below_band && !above_band)
                begin
                    // Inside the band: the heat phase is complete.
                    drive_next[DRV_HEATER] = 1'b0;
                    heat_armed_next        = 1'b0;
                    phase_next             = PH_FOG;
                end
                else if (heat_expired)
                begin
                    drive_next[DRV_HEATER] = 1'b0;
                    phase_next             = PH_FAULT;
                end
                else
                begin
                    drive_next[DRV_HEATER] = below_band ? 1'b1
                                           : (above_band ? 1'b0 : drive_reg[DRV_HEATER]);
                end
            end
            PH_FOG:
            begin
                if (over || wfault)
                begin
                    // Drives are left as they stand; fault clears them next tick.
                    phase_next = PH_FAULT;
                end
                else
                begin
                    drive_next[DRV_DOSE]  = 1'b1;
                    drive_next[DRV_VENTS] = 1'b1;
                    if (below_band)
                    begin
                        drive_next[DRV_HEATER] = 1'b1;
                    end
                    else if (above_band)
                    begin
                        drive_next[DRV_HEATER] = 1'b0;
                    end
                end
            end
            default:
            begin
                // Fault, and any unused code, which behaves as fault.
                drive_next = '0;
            end
        endcase

        phase_out = (phase_next > PH_FAULT) ? PH_FAULT : phase_next;

        m_data_next                 = '0;
        m_data_next[PHASE_W-1:0]    = phase_out;
        m_data_next[OUT_PUMP_BIT]   = drive_next[DRV_PUMP];
        m_data_next[OUT_HEATER_BIT] = drive_next[DRV_HEATER];
        m_data_next[OUT_DOSE_BIT]   = drive_next[DRV_DOSE];
        m_data_next[OUT_VENTS_BIT]  = drive_next[DRV_VENTS];
    end

    // Phase machine state, updated once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            fill_start_reg <= '0;
            fill_armed_reg <= 1'b0;
            heat_start_reg <= '0;
            heat_armed_reg <= 1'b0;
            drive_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            fill_start_reg <= fill_start_next;
            fill_armed_reg <= fill_armed_next;
            heat_start_reg <= heat_start_next;
            heat_armed_reg <= heat_armed_next;
            drive_reg      <= drive_next;
        end
    end

    // Output register: loaded with each accepted tick, emptied when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Configuration registers; bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_timeout_reg <= FILL_TIMEOUT_RST;
            heat_timeout_reg <= HEAT_TIMEOUT_RST;
            band_low_reg     <= BAND_LOW_RST;
            band_high_reg    <= BAND_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILL_TIMEOUT: fill_timeout_reg <= cfg_data;
                CFG_HEAT_TIMEOUT: heat_timeout_reg <= cfg_data;
                CFG_BAND_LOW:     band_low_reg     <= signed'(cfg_data[TEMP_W-1:0]);
                CFG_BAND_HIGH:    band_high_reg    <= signed'(cfg_data[TEMP_W-1:0]);
            endcase
        end
    end

endmodule

FILE: sv/fhfs_checker.sv
// Port-level checker for the fill, heat and fog sequencer, bound to the top level.
// Depends on fhfs_pkg and on the macros in fill_heat_fog_sequencer_assert.svh.
`include "fill_heat_fog_sequencer_assert.svh"

module fhfs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [fhfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import fhfs_pkg::*;

    logic [PHASE_W-1:0] out_phase;

    assign out_phase = m_axis_tdata[PHASE_W-1:0];

    // A stalled result stays offered and unchanged.
    `FHFS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata))

    // Every accepted tick yields a result in the following cycle.
    `FHFS_ASSERT_NEXT(a_tick_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid)

    // The pump runs only while filling.
    `FHFS_ASSERT_SAME(a_pump_in_fill, m_axis_tvalid && m_axis_tdata[OUT_PUMP_BIT],
                      out_phase == PH_FILL)

    // Dosing is only ever on in fog, or on the first tick of a fault from fog.
    `FHFS_ASSERT_SAME(a_dose_in_fog, m_axis_tvalid && m_axis_tdata[OUT_DOSE_BIT],
                      out_phase == PH_FOG || out_phase == PH_FAULT)

endmodule

bind fill_heat_fog_sequencer fhfs_checker u_fhfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: dv/fill_heat_fog_sequencer_tb.sv
// Self-checking testbench for the fill, heat and fog sequencer.
// Needs fhfs_pkg and fill_heat_fog_sequencer; predicts every result transaction in place.
// Directed phase walks are followed by long random runs under varied stream back pressure.
module fill_heat_fog_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fhfs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    // One run tick as the sender sees it.
    typedef struct {
        logic [31:0]        time_ms;
        logic               water;
        logic signed [13:0] temp;
        logic               over;
        logic               wfault;
    } tick_t;

    // Phase and drive levels that one tick should produce.
    typedef struct {
        phase_t phase;
        logic   pump;
        logic   heater;
        logic   dose;
        logic   vents;
    } drive_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_FILL_TIMEOUT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Percentages of cycles in which the sender leaves a gap and the receiver stalls.
    int unsigned src_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    // Cycles for which the receiver is held off completely.
    int          hold_left = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    // Shadow of the sequencer state and its configuration.
    phase_t             seq_phase = PH_IDLE;
    logic [31:0]        fill_t0 = '0;
    logic               fill_running = 1'b0;
    logic [31:0]        heat_t0 = '0;
    logic               heat_running = 1'b0;
    logic [3:0]         drive = '0;
    logic [31:0]        lim_fill = FILL_TIMEOUT_RST;
    logic [31:0]        lim_heat = HEAT_TIMEOUT_RST;
    logic signed [13:0] band_lo = BAND_LOW_RST;
    logic signed [13:0] band_hi = BAND_HIGH_RST;

    // Results still owed by the block, oldest first.
    drive_result_t pending_drives[$];

    fill_heat_fog_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // The heater rule shared by heat and fog: on below the band, off above it, and
    // otherwise left as it was. With an inverted band the lower rule wins.
    function automatic logic band_heater(logic signed [13:0] temp);
        if (temp < band_lo)
            return 1'b1;
        if (temp > band_hi)
            return 1'b0;
        return drive[DRV_HEATER];
    endfunction

    // Advances the shadow sequencer by one tick and returns what the block should report.
    // Elapsed times are taken on 32 bits, so a counter that wraps is measured correctly.
    function automatic drive_result_t advance_sequencer(tick_t t);
        drive_result_t r;
        case (seq_phase)
            PH_IDLE:
                seq_phase = PH_FILL;
            PH_FILL:
            begin
                drive[DRV_PUMP] = 1'b1;
                if (!fill_running)
                begin
                    fill_running = 1'b1;
                    fill_t0 = t.time_ms;
                end
                if (t.water)
                begin
                    drive[DRV_PUMP] = 1'b0;
                    fill_running = 1'b0;
                    seq_phase = PH_HEAT;
                end
                else if (32'(t.time_ms - fill_t0) > lim_fill)
                begin
                    drive[DRV_PUMP] = 1'b0;
                    seq_phase = PH_FAULT;
                end
            end
            PH_HEAT:
            begin
                if (!heat_running)
                begin
                    heat_running = 1'b1;
                    heat_t0 = t.time_ms;
                end
                if (t.over)
                begin
                    drive[DRV_HEATER] = 1'b0;
                    seq_phase = PH_FAULT;
                end
                else
                begin
                    drive[DRV_HEATER] = band_heater(t.temp);
                    if (t.temp >= band_lo && t.temp <= band_hi)
                    begin
                        drive[DRV_HEATER] = 1'b0;
                        heat_running = 1'b0;
                        seq_phase = PH_FOG;
                    end
                    else if (32'(t.time_ms - heat_t0) > lim_heat)
                    begin
                        drive[DRV_HEATER] = 1'b0;
                        seq_phase = PH_FAULT;
                    end
                end
            end
            PH_FOG:
            begin
                // Fault entry from fog keeps this tick's drives; they drop on the next tick.
                if (t.over || t.wfault)
                    seq_phase = PH_FAULT;
                else
                begin
                    drive[DRV_DOSE] = 1'b1;
                    drive[DRV_VENTS] = 1'b1;
                    drive[DRV_HEATER] = band_heater(t.temp);
                end
            end
            default:
                drive = '0;
        endcase
        r.phase = seq_phase;
        r.pump = drive[DRV_PUMP];
        r.heater = drive[DRV_HEATER];
        r.dose = drive[DRV_DOSE];
        r.vents = drive[DRV_VENTS];
        return r;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        t.time_ms = $urandom();
        t.water = 1'($urandom_range(0, 1));
        t.temp = 14'($urandom());
        t.over = 1'($urandom_range(0, 1));
        t.wfault = 1'($urandom_range(0, 1));
        return t;
    endfunction

    // A band register word: the temperature in the low 14 bits and random bits above,
    // which the block must ignore.
    function automatic logic [31:0] band_word(int v);
        logic [31:0] junk;
        junk = $urandom();
        return {junk[31:14], 14'(v)};
    endfunction

    // Offers one tick, leaving random gaps first, and records its expected result once
    // the transaction has been accepted. The valid is left high on return so that
    // back-to-back ticks never lower and raise it within one time step.
    task automatic send_tick(tick_t t);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, t.wfault, t.over, t.temp, t.water, t.time_ms};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_drives.push_back(advance_sequencer(t));
    endtask

    // Waits until every owed result has been taken, then writes all four registers.
    task automatic write_regs(input logic [31:0] fill_raw, heat_raw, low_raw, high_raw);
        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FILL_TIMEOUT;
        cfg_data <= fill_raw;
        @(posedge clk);
        cfg_index <= CFG_HEAT_TIMEOUT;
        cfg_data <= heat_raw;
        @(posedge clk);
        cfg_index <= CFG_BAND_LOW;
        cfg_data <= low_raw;
        @(posedge clk);
        cfg_index <= CFG_BAND_HIGH;
        cfg_data <= high_raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_fill = fill_raw;
        lim_heat = heat_raw;
        band_lo = low_raw[13:0];
        band_hi = high_raw[13:0];
    endtask

    // Writes a random band, either well ordered with room on both sides or inverted.
    task automatic write_random_band(input logic [31:0] fill_raw, heat_raw, input bit inverted);
        int lo;
        int hi;
        if (inverted)
        begin
            hi = int'($urandom_range(0, 16382)) - 8192;
            lo = hi + 1 + int'($urandom_range(0, 8190 - hi));
        end
        else
        begin
            lo = int'($urandom_range(0, 16381)) - 8191;
            hi = lo + int'($urandom_range(0, 8190 - lo));
        end
        write_regs(fill_raw, heat_raw, band_word(lo), band_word(hi));
    endtask

    // The idle tick ignores every field; fill then starts its timer just below the wrap.
    task automatic test_fill_timing();
        tick_t t;
        t = random_tick();
        t.water = 1'b1;
        t.over = 1'b1;
        t.wfault = 1'b1;
        t.temp = -14'sd8192;
        send_tick(t);
        t = random_tick();
        t.time_ms = 32'hFFFF_F000;
        t.water = 1'b0;
        t.over = 1'b1;
        t.temp = 14'sd8191;
        send_tick(t);
        // Elapsed equal to the default timeout, across the wrap, is still allowed.
        t.time_ms = 32'hFFFF_F000 + 32'd120000;
        t.over = 1'b0;
        send_tick(t);
        write_regs(32'hFFFF_FFFF, lim_heat, band_word(1728), band_word(1840));
        t.time_ms = 32'hFFFF_EFFF;
        send_tick(t);
        write_regs(32'd0, lim_heat, band_word(1728), band_word(1840));
        t.time_ms = 32'hFFFF_F000;
        send_tick(t);
    endtask

    // Long fill runs with times kept within the timeout, so that fill never faults.
    task automatic test_fill_random();
        tick_t t;
        logic [31:0] lim;
        for (int seg = 0; seg < 3; seg++)
        begin
            lim = (seg == 0) ? $urandom_range(0, 15) : (seg == 1) ? $urandom() : 32'hFFFF_FFFF;
            write_regs(lim, $urandom(), band_word($urandom()), band_word($urandom()));
            for (int i = 0; i < 100; i++)
            begin
                t = random_tick();
                t.water = 1'b0;
                t.time_ms = fill_t0 + $urandom_range(0, lim_fill);
                send_tick(t);
            end
        end
    endtask

    // Water wins over an expired fill timer; heat then checks its timer edges and the
    // inverted band.
    task automatic test_heat_band_edges();
        tick_t t;
        write_regs(32'd1000, lim_heat, band_word(1728), band_word(1840));
        t = random_tick();
        t.water = 1'b1;
        t.over = 1'b1;
        t.wfault = 1'b1;
        t.time_ms = fill_t0 + lim_fill + 32'd1;
        send_tick(t);
        write_regs(lim_fill, 32'd0, band_word(1728), band_word(1840));
        t = random_tick();
        t.over = 1'b0;
        t.temp = 14'sd1727;
        send_tick(t);
        write_regs(lim_fill, HEAT_TIMEOUT_RST, band_word(1728), band_word(1840));
        t.time_ms = heat_t0 + 32'd600000;
        t.temp = 14'sd1841;
        send_tick(t);
        write_regs(lim_fill, 32'hFFFF_FFFF, band_word(100), band_word(-100));
        t.time_ms = heat_t0 - 32'd1;
        t.temp = 14'sd0;
        send_tick(t);
        t.temp = 14'sd200;
        send_tick(t);
        t.temp = -14'sd200;
        send_tick(t);
    endtask

    // Heat runs that stay outside the band and within the timeout.
    task automatic test_heat_random();
        tick_t t;
        logic [31:0] lim;
        for (int seg = 0; seg < 4; seg++)
        begin
            lim = (seg == 0) ? $urandom_range(0, 7) : (seg == 2) ? 32'hFFFF_FFFF : $urandom();
            write_random_band($urandom(), lim, seg == 2);
            for (int i = 0; i < 100; i++)
            begin
                t = random_tick();
                t.over = 1'b0;
                t.time_ms = heat_t0 + $urandom_range(0, lim_heat);
                if (band_lo <= band_hi)
                begin
                    if ($urandom_range(0, 1))
                        t.temp = 14'(-8192 + int'($urandom_range(0, int'(band_lo) + 8191)));
                    else
                        t.temp = 14'(int'(band_hi) + 1
                                     + int'($urandom_range(0, 8190 - int'(band_hi))));
                end
                send_tick(t);
            end
        end
    endtask

    // Entering the band beats an expired heat timer; fog then follows the band edges.
    task automatic test_fog_entry_and_band();
        tick_t t;
        write_regs(lim_fill, lim_heat, band_word(1728), band_word(1840));
        t = random_tick();
        t.over = 1'b0;
        t.wfault = 1'b0;
        t.time_ms = heat_t0 + lim_heat + 32'd1;
        t.temp = 14'sd1728;
        send_tick(t);
        t.temp = 14'sd1727;
        send_tick(t);
        t.temp = 14'sd1840;
        send_tick(t);
        t.temp = 14'sd1841;
        send_tick(t);
        t.temp = 14'sd1728;
        send_tick(t);
        write_regs($urandom(), $urandom(), band_word(-8192), band_word(8191));
        t.temp = -14'sd8192;
        send_tick(t);
        t.temp = 14'sd8191;
        send_tick(t);
    endtask

    // Fog runs with no fault verdicts, rotating through wide, inverted, random and
    // fully inverted bands. The second half runs with no idling on either side.
    task automatic test_fog_random();
        tick_t t;
        for (int seg = 0; seg < 8; seg++)
        begin
            if (seg == 4)
            begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end
            case (seg % 4)
                0: write_regs($urandom(), $urandom(), band_word(-8192), band_word(8191));
                1: write_random_band($urandom(), $urandom(), 1'b1);
                2: write_random_band($urandom(), $urandom(), 1'b0);
                default: write_regs($urandom(), $urandom(), band_word(8191), band_word(-8192));
            endcase
            for (int i = 0; i < 100; i++)
            begin
                t = random_tick();
                t.over = 1'b0;
                t.wfault = 1'b0;
                send_tick(t);
            end
        end
    endtask

    // The receiver is held off for a long stretch while ticks keep coming, so the
    // output register fills and the input must stall.
    task automatic test_output_backpressure();
        tick_t t;
        hold_left = 400;
        for (int i = 0; i < 30; i++)
        begin
            t = random_tick();
            t.over = 1'b0;
            t.wfault = 1'b0;
            send_tick(t);
        end
    endtask

    // A fault verdict in fog latches the fault; later ticks of any kind keep it there
    // with every drive low.
    task automatic test_fault_latch();
        tick_t t;
        logic [1:0] verdicts;
        t = random_tick();
        verdicts = 2'($urandom_range(1, 3));
        t.over = verdicts[0];
        t.wfault = verdicts[1];
        send_tick(t);
        for (int i = 0; i < 40; i++)
            send_tick(random_tick());
    endtask

    // The receiver stalls at random, unless it is being held off completely.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Each result transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("result transaction with no expectation: tdata %h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (m_axis_tdata[PHASE_W-1:0] !== want.phase)
                begin
                    $error("phase: expected %0d, actual %0d", want.phase,
                           m_axis_tdata[PHASE_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_PUMP_BIT] !== want.pump)
                begin
                    $error("pump_on: expected %0b, actual %0b", want.pump,
                           m_axis_tdata[OUT_PUMP_BIT]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_HEATER_BIT] !== want.heater)
                begin
                    $error("heater_on: expected %0b, actual %0b", want.heater,
                           m_axis_tdata[OUT_HEATER_BIT]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_DOSE_BIT] !== want.dose)
                begin
                    $error("dosing_valve_on: expected %0b, actual %0b", want.dose,
                           m_axis_tdata[OUT_DOSE_BIT]);
                    fail_count++;
                end
                if (m_axis_tdata[OUT_VENTS_BIT] !== want.vents)
                begin
                    $error("vents_on: expected %0b, actual %0b", want.vents,
                           m_axis_tdata[OUT_VENTS_BIT]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Fill and heat: the sender rarely pauses, the receiver mostly stalls.
        src_gap_pct = 7;
        sink_stall_pct = 84;
        test_fill_timing();
        test_fill_random();
        test_heat_band_edges();
        test_heat_random();

        // Fog: the other way round, then no idling at all from half way through.
        src_gap_pct = 84;
        sink_stall_pct = 7;
        test_fog_entry_and_band();
        test_fog_random();
        test_output_backpressure();
        test_fault_latch();

        s_axis_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/fhfs_pkg.sv
sv/fill_heat_fog_sequencer.sv
sv/fhfs_checker.sv
dv/fill_heat_fog_sequencer_tb.sv
